### rtl/asaf_pkg.sv
// shared types and constants for the add/sub alu with flags
// no dependencies

package asaf_pkg;

    localparam int XLEN    = 64;
    localparam int HALF    = XLEN / 2;
    localparam int NUM_GPR = 31;
    localparam int REG_W   = 5;
    localparam int SHAMT_W = 6;

    localparam logic [REG_W-1:0] REG_ZR = REG_W'(NUM_GPR);

    localparam logic [XLEN-1:0] LOW_MASK = {{HALF{1'b0}}, {HALF{1'b1}}};

    localparam logic [1:0] SHIFT_LSL = 2'd0;
    localparam logic [1:0] SHIFT_LSR = 2'd1;
    localparam logic [1:0] SHIFT_ASR = 2'd2;

    typedef enum logic [2:0] {
        CMD_ADD_IMM,
        CMD_ADD_REG,
        CMD_SUB_IMM,
        CMD_SUB_REG,
        CMD_ADC,
        CMD_SBC,
        CMD_LOAD,
        CMD_READ
    } cmd_t;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } nzcv_t;

    typedef struct packed {
        logic             en;
        logic [REG_W-1:0] addr;
        logic [XLEN-1:0]  data;
    } gpr_wr_t;

    typedef struct packed {
        logic            en;
        logic [XLEN-1:0] data;
    } sp_wr_t;

    typedef struct packed {
        cmd_t               command;
        logic [REG_W-1:0]   dest_reg;
        logic [REG_W-1:0]   src1_reg;
        logic [REG_W-1:0]   src2_reg;
        logic [XLEN-1:0]    immediate;
        logic [1:0]         shift_kind;
        logic [SHAMT_W-1:0] shift_amount;
        logic               update_flags;
        logic               wide_mode;
    } item_t;

endpackage

### rtl/asaf_regfile.sv
// 31 x 64 general register file with registered reads and write bypass
// depends on asaf_pkg

module asaf_regfile (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [asaf_pkg::REG_W-1:0]      rd_addr1,
    input  logic [asaf_pkg::REG_W-1:0]      rd_addr2,
    input  asaf_pkg::gpr_wr_t               wr,
    output logic [asaf_pkg::XLEN-1:0]       rd_data1,
    output logic [asaf_pkg::XLEN-1:0]       rd_data2
);
    import asaf_pkg::*;

    logic [XLEN-1:0]    mem [0:NUM_GPR-1];
    logic [NUM_GPR-1:0] valid_reg;
    logic [XLEN-1:0]    data1_reg;
    logic [XLEN-1:0]    data2_reg;
    logic               ok1_reg;
    logic               ok2_reg;
    logic               hit1;
    logic               hit2;

    assign hit1 = wr.en && (wr.addr == rd_addr1);
    assign hit2 = wr.en && (wr.addr == rd_addr2);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            data1_reg <= hit1 ? wr.data : mem[rd_addr1];
            data2_reg <= hit2 ? wr.data : mem[rd_addr2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ok1_reg   <= 1'b0;
            ok2_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                ok1_reg <= (rd_addr1 != REG_ZR) && (hit1 || valid_reg[rd_addr1]);
                ok2_reg <= (rd_addr2 != REG_ZR) && (hit2 || valid_reg[rd_addr2]);
            end
        end
    end

    // register 31 and never-written entries read as zero
    assign rd_data1 = ok1_reg ? data1_reg : '0;
    assign rd_data2 = ok2_reg ? data2_reg : '0;

`ifndef SYNTHESIS
    a_no_zr_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> wr.addr != REG_ZR)
        else $error("write to register 31 reached the register file");
`endif

endmodule

### rtl/asaf_exec.sv
// operand selection, shifter, 64-bit adder and nzcv generation
// depends on asaf_pkg

module asaf_exec (
    input  asaf_pkg::item_t                 item,
    input  logic [asaf_pkg::XLEN-1:0]       rn_gpr,
    input  logic [asaf_pkg::XLEN-1:0]       rm_gpr,
    input  logic [asaf_pkg::XLEN-1:0]       sp,
    input  asaf_pkg::nzcv_t                 flags_in,
    output logic [asaf_pkg::XLEN-1:0]       result,
    output asaf_pkg::nzcv_t                 flags_out,
    output asaf_pkg::gpr_wr_t               gpr_wr,
    output asaf_pkg::sp_wr_t                sp_wr
);
    import asaf_pkg::*;

    logic [XLEN-1:0]        mask;
    logic [XLEN-1:0]        rn_sp;
    logic [XLEN-1:0]        sh_src;
    logic signed [XLEN-1:0] asr_src;
    logic [SHAMT_W-1:0]     amt;
    logic [XLEN-1:0]        sh_raw;
    logic [XLEN-1:0]        shifted;
    logic [XLEN-1:0]        a_raw;
    logic [XLEN-1:0]        b_raw;
    logic [XLEN-1:0]        a_op;
    logic [XLEN-1:0]        b_op;
    logic [XLEN-1:0]        b_inv;
    logic [XLEN:0]          sum;
    logic [XLEN-1:0]        sum_r;
    logic [XLEN-1:0]        v_bits;
    logic                   is_sub;
    logic                   is_arith;
    logic                   with_carry;
    logic                   carry_in;
    nzcv_t                  new_flags;

    always_comb
    begin
        mask  = item.wide_mode ? '1 : LOW_MASK;
        rn_sp = (item.src1_reg == REG_ZR) ? sp : rn_gpr;

        // second register operand shifter
        sh_src  = rm_gpr & mask;
        amt     = item.wide_mode ? item.shift_amount
                                 : {1'b0, item.shift_amount[SHAMT_W-2:0]};
        asr_src = item.wide_mode ? sh_src : {{HALF{sh_src[HALF-1]}}, sh_src[HALF-1:0]};
        case (item.shift_kind)
            SHIFT_LSL: sh_raw = sh_src << amt;
            SHIFT_LSR: sh_raw = sh_src >> amt;
            SHIFT_ASR: sh_raw = asr_src >>> amt;
            default:   sh_raw = sh_src;
        endcase
        shifted = sh_raw & mask;

        unique case (item.command) inside
            CMD_ADD_REG, CMD_SUB_REG:
            begin
                a_raw = rn_sp;
                b_raw = shifted;
            end
            CMD_ADC, CMD_SBC:
            begin
                a_raw = rn_gpr;
                b_raw = rm_gpr;
            end
            default:
            begin
                a_raw = rn_sp;
                b_raw = item.immediate;
            end
        endcase

        is_sub     = (item.command == CMD_SUB_IMM) || (item.command == CMD_SUB_REG)
                     || (item.command == CMD_SBC);
        with_carry = (item.command == CMD_ADC) || (item.command == CMD_SBC);
        is_arith   = (item.command != CMD_LOAD) && (item.command != CMD_READ);
        carry_in   = with_carry ? flags_in.c : is_sub;

        a_op  = a_raw & mask;
        b_op  = b_raw & mask;
        b_inv = is_sub ? (~b_op & mask) : b_op;

        sum    = {1'b0, a_op} + {1'b0, b_inv} + {{XLEN{1'b0}}, carry_in};
        sum_r  = sum[XLEN-1:0] & mask;
        v_bits = ~(a_op ^ b_inv) & (a_op ^ sum_r);

        new_flags.n = item.wide_mode ? sum_r[XLEN-1] : sum_r[HALF-1];
        new_flags.z = (sum_r == '0);
        new_flags.c = item.wide_mode ? sum[XLEN] : sum[HALF];
        new_flags.v = item.wide_mode ? v_bits[XLEN-1] : v_bits[HALF-1];

        unique case (item.command)
            CMD_LOAD: result = item.immediate & mask;
            CMD_READ: result = a_op;
            default:  result = sum_r;
        endcase

        flags_out = (is_arith && item.update_flags) ? new_flags : flags_in;

        gpr_wr.en   = (item.command != CMD_READ) && (item.dest_reg != REG_ZR);
        gpr_wr.addr = item.dest_reg;
        gpr_wr.data = result;

        // register 31 as destination: sp for plain add/sub with sp source, and for load
        sp_wr.en   = (item.dest_reg == REG_ZR)
                     && ((item.command == CMD_LOAD)
                         || (!with_carry && is_arith && (item.src1_reg == REG_ZR)));
        sp_wr.data = result;
    end

endmodule

### rtl/add_sub_alu_with_flags.sv
// top level of the add/sub alu with nzcv flags: handshake, input and result
// registers, stack pointer and flag state
// depends on asaf_pkg, asaf_regfile, asaf_exec
//
// usage:
//   command channel: cmd_valid / cmd_stall with the instruction fields as ports.
//   an item is taken at a clock edge where cmd_valid is high and cmd_stall low.
//   result channel: res_valid / res_stall with result_value and flag_n..flag_v.
//   every item gives exactly one result item, in order.
//   an item first sits in the input register, where the register file read
//   data arrives, then one adder/shifter pass writes the result register
//   (which raises res_valid) and updates the register file, stack pointer
//   and the flags at the same edge.
//   throughput: one item per cycle when not stalled; an item may use the
//   result of the one right before it, the register file read bypasses the
//   write in flight. when res_stall holds a result, the item behind it waits
//   in the input register and cmd_stall rises; nothing is lost or repeated.
//   reset (rst_n low, asynchronous) empties both registers and clears all
//   general registers, the stack pointer and the flags at once.

module add_sub_alu_with_flags (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  logic [2:0]                          command,
    input  logic [asaf_pkg::REG_W-1:0]          dest_reg,
    input  logic [asaf_pkg::REG_W-1:0]          src1_reg,
    input  logic [asaf_pkg::REG_W-1:0]          src2_reg,
    input  logic signed [asaf_pkg::XLEN-1:0]    immediate,
    input  logic [1:0]                          shift_kind,
    input  logic [asaf_pkg::SHAMT_W-1:0]        shift_amount,
    input  logic                                update_flags,
    input  logic                                wide_mode,
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic [asaf_pkg::XLEN-1:0]           result_value,
    output logic                                flag_n,
    output logic                                flag_z,
    output logic                                flag_c,
    output logic                                flag_v
);
    import asaf_pkg::*;

    logic            cmd_accept;
    logic            out_free;
    logic            s1_advance;
    logic            s1_valid_reg;
    item_t           s1_item_reg;
    item_t           item_next;
    logic            res_valid_reg;
    logic [XLEN-1:0] result_reg;
    nzcv_t           res_flags_reg;
    logic [XLEN-1:0] sp_reg;
    nzcv_t           flags_reg;
    logic [XLEN-1:0] rn_gpr;
    logic [XLEN-1:0] rm_gpr;
    logic [XLEN-1:0] exec_result;
    nzcv_t           exec_flags;
    gpr_wr_t         exec_gpr_wr;
    gpr_wr_t         gpr_wr;
    sp_wr_t          sp_wr;

    assign out_free   = !res_valid_reg || !res_stall;
    assign s1_advance = s1_valid_reg && out_free;
    assign cmd_stall  = s1_valid_reg && !out_free;
    assign cmd_accept = cmd_valid && !cmd_stall;

    always_comb
    begin
        item_next.command      = cmd_t'(command);
        item_next.dest_reg     = dest_reg;
        item_next.src1_reg     = src1_reg;
        item_next.src2_reg     = src2_reg;
        item_next.immediate    = immediate;
        item_next.shift_kind   = shift_kind;
        item_next.shift_amount = shift_amount;
        item_next.update_flags = update_flags;
        item_next.wide_mode    = wide_mode;
    end

    asaf_regfile u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (cmd_accept),
        .rd_addr1 (src1_reg),
        .rd_addr2 (src2_reg),
        .wr       (gpr_wr),
        .rd_data1 (rn_gpr),
        .rd_data2 (rm_gpr)
    );

    asaf_exec u_exec (
        .item      (s1_item_reg),
        .rn_gpr    (rn_gpr),
        .rm_gpr    (rm_gpr),
        .sp        (sp_reg),
        .flags_in  (flags_reg),
        .result    (exec_result),
        .flags_out (exec_flags),
        .gpr_wr    (exec_gpr_wr),
        .sp_wr     (sp_wr)
    );

    always_comb
    begin
        gpr_wr    = exec_gpr_wr;
        gpr_wr.en = exec_gpr_wr.en && s1_advance;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            s1_item_reg <= item_next;
        end
    end

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg    <= '0;
            flags_reg <= '0;
        end
        else if (s1_advance)
        begin
            flags_reg <= exec_flags;
            if (sp_wr.en)
            begin
                sp_reg <= sp_wr.data;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            result_reg    <= exec_result;
            res_flags_reg <= exec_flags;
        end
    end

    assign res_valid    = res_valid_reg;
    assign result_value = result_reg;
    assign flag_n       = res_flags_reg.n;
    assign flag_z       = res_flags_reg.z;
    assign flag_c       = res_flags_reg.c;
    assign flag_v       = res_flags_reg.v;

`ifndef SYNTHESIS
    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_advance |=> $stable(flags_reg))
        else $error("flags changed without an item completing");

    a_narrow_zext: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && !s1_item_reg.wide_mode |-> exec_result[XLEN-1:HALF] == '0)
        else $error("32-bit result not zero-extended");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> s1_valid_reg && res_valid_reg)
        else $error("command stalled with free pipeline");

    a_sp_update: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && sp_wr.en |=> sp_reg == $past(exec_result))
        else $error("stack pointer write lost");
`endif

endmodule
